[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLKRST(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Same, on the usual clk / rst_n pair.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLKRST(label, clk, rst_n, prop, msg)

`endif

[rtl/sal_pkg.sv]
// Types and constants of the sensor alarm latch.
`timescale 1ns / 1ps

package sal_pkg;

    localparam int NUM_ALARMS = 6;
    localparam int NUM_READINGS = 3;
    localparam int AUTO_ACK_BIT = 15;
    localparam int GROUP_EN_LSB = 12;
    localparam logic [15:0] CONTROL_MASK = 16'hF000;
    localparam logic [7:0] HYST_RESET = 8'd2;

    // action codes
    localparam logic [1:0] ACT_CHECK = 2'd0;
    localparam logic [1:0] ACT_ACK = 2'd1;
    localparam logic [1:0] ACT_OFFSCAN = 2'd2;

    // event kinds
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DETECT = 2'd1;
    localparam logic [1:0] EV_CLEAR = 2'd2;

    // classified item, front to back
    typedef struct packed {
        logic [15:0] status;                          // start status (final if no events)
        logic [NUM_ALARMS-1:0] ev_mask;               // alarms with an event
        logic [NUM_ALARMS-1:0] ev_clear;              // event is a clear, else a detect
        logic [NUM_READINGS-1:0][15:0] rd;
        logic [NUM_ALARMS-1:0][15:0] sp;
    } sal_entry_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [2:0] alarm_number;
        logic [15:0] reading;
        logic [15:0] setpoint;
        logic [15:0] status_out;
        logic last;
    } sal_result_t;

endpackage

[rtl/sal_front.sv]
// Front end: hysteresis register and classification of one item.
`timescale 1ns / 1ps

module sal_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic [1:0]        action,
    input  logic [15:0]       status_in,
    input  logic signed [15:0] temperature,
    input  logic signed [15:0] humidity,
    input  logic signed [15:0] pressure,
    input  logic signed [15:0] temp_low_point,
    input  logic signed [15:0] temp_high_point,
    input  logic signed [15:0] hum_low_point,
    input  logic signed [15:0] hum_high_point,
    input  logic signed [15:0] pres_low_point,
    input  logic signed [15:0] pres_high_point,
    output sal_pkg::sal_entry_t entry
);
    import sal_pkg::*;

    logic [7:0] hyst_reg;
    logic [7:0] hyst_next;
    logic [NUM_READINGS-1:0][15:0] rd_w;
    logic [NUM_ALARMS-1:0][15:0] sp_w;
    logic [NUM_READINGS-1:0] grp_on;
    logic [15:0] st_base;
    logic [NUM_ALARMS-1:0] ev_mask;
    logic [NUM_ALARMS-1:0] ev_clear;

    always_comb
    begin
        hyst_next = cfg_we ? cfg_wdata : hyst_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg <= HYST_RESET;
        end
        else
        begin
            hyst_reg <= hyst_next;
        end
    end

    assign rd_w = {pressure, humidity, temperature};
    assign sp_w = {pres_high_point, pres_low_point, hum_high_point, hum_low_point,
                   temp_high_point, temp_low_point};

    // the walk stops at the first disabled group
    assign grp_on[0] = status_in[GROUP_EN_LSB];
    assign grp_on[1] = grp_on[0] & status_in[GROUP_EN_LSB+1];
    assign grp_on[2] = grp_on[1] & status_in[GROUP_EN_LSB+2];

    // alarms are independent: each only touches its own det/ack pair
    always_comb
    begin
        logic signed [17:0] r;
        logic signed [17:0] s;
        logic signed [17:0] lim;
        logic [1:0] pair;
        logic hit;
        logic still;
        ev_mask = '0;
        ev_clear = '0;
        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            r = 18'($signed(rd_w[k/2]));
            s = 18'($signed(sp_w[k]));
            pair = status_in[2*k +: 2];
            if (k % 2 == 1)
            begin
                lim = s - $signed({10'd0, hyst_reg});
                hit = (r >= s);
                still = (r >= lim);
            end
            else
            begin
                lim = s + $signed({10'd0, hyst_reg});
                hit = (r <= s);
                still = (r <= lim);
            end
            if (action == ACT_CHECK && grp_on[k/2])
            begin
                if (pair == 2'b11 && !still)
                begin
                    ev_mask[k] = 1'b1;
                    ev_clear[k] = 1'b1;
                end
                else if (pair == 2'b00 && hit)
                begin
                    ev_mask[k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        st_base = status_in;
        case (action)
            ACT_CHECK:
            begin
                st_base = status_in;
            end
            ACT_ACK:
            begin
                for (int k = 0; k < NUM_ALARMS; k++)
                begin
                    if (status_in[2*k +: 2] == 2'b01)
                    begin
                        st_base[2*k+1] = 1'b1;
                    end
                end
            end
            ACT_OFFSCAN:
            begin
                st_base = status_in & CONTROL_MASK;
            end
            default:
            begin
                st_base = status_in;
            end
        endcase
    end

    always_comb
    begin
        entry.status = st_base;
        entry.ev_mask = ev_mask;
        entry.ev_clear = ev_clear;
        entry.rd = rd_w;
        entry.sp = sp_w;
    end

endmodule

[rtl/sal_queue.sv]
// Small register queue between the front and back ends.
`timescale 1ns / 1ps

module sal_queue #(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  sal_pkg::sal_entry_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output sal_pkg::sal_entry_t rd_data,
    output logic                not_empty
);
    import sal_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sal_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_wr, do_rd;

    assign full = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_wr = wr_en & ~full;
    assign do_rd = rd_en & not_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/sal_back.sv]
// Back end: walks the events of one item and fills the result register.
`timescale 1ns / 1ps

module sal_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sal_pkg::sal_entry_t  q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_pop,
    output sal_pkg::sal_result_t out_data
);
    import sal_pkg::*;

    sal_entry_t cur_reg;
    logic cur_valid_reg, cur_valid_next;
    logic [NUM_ALARMS-1:0] rem_reg, rem_next;
    logic [15:0] run_st_reg, run_st_next;
    logic out_valid_reg, out_valid_next;
    sal_result_t out_reg;

    logic out_free, emit, finish, has_ev;
    logic [2:0] idx;
    logic [NUM_ALARMS-1:0] rem_after;
    logic [15:0] st_after;
    sal_result_t res;

    assign out_free = ~out_valid_reg | out_pop;
    assign emit = cur_valid_reg & out_free;
    assign has_ev = |rem_reg;

    // lowest pending alarm goes first
    always_comb
    begin
        idx = '0;
        for (int k = NUM_ALARMS - 1; k >= 0; k--)
        begin
            if (rem_reg[k])
            begin
                idx = 3'(k);
            end
        end
    end

    always_comb
    begin
        rem_after = rem_reg;
        st_after = run_st_reg;
        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            if (has_ev && idx == 3'(k))
            begin
                rem_after[k] = 1'b0;
                if (cur_reg.ev_clear[k])
                begin
                    st_after[2*k +: 2] = 2'b00;
                end
                else
                begin
                    st_after[2*k] = 1'b1;
                    st_after[2*k+1] = run_st_reg[AUTO_ACK_BIT];
                end
            end
        end
    end

    always_comb
    begin
        res.status_out = st_after;
        res.last = (rem_after == '0);
        if (has_ev)
        begin
            res.event_kind = cur_reg.ev_clear[idx] ? EV_CLEAR : EV_DETECT;
            res.alarm_number = idx;
            res.reading = cur_reg.rd[idx[2:1]];
            res.setpoint = cur_reg.sp[idx];
        end
        else
        begin
            res.event_kind = EV_NONE;
            res.alarm_number = '0;
            res.reading = '0;
            res.setpoint = '0;
        end
    end

    assign finish = emit & (rem_after == '0);
    assign q_pop = q_valid & (~cur_valid_reg | finish);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        rem_next = rem_reg;
        run_st_next = run_st_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            rem_next = q_data.ev_mask;
            run_st_next = q_data.status;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            rem_next = rem_after;
            run_st_next = st_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        rem_reg <= rem_next;
        run_st_reg <= run_st_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

[rtl/sensor_alarm_latch_with_ack.sv]
// Top level of the latched hi/lo sensor alarm block with acknowledge.
`timescale 1ns / 1ps

// Channel   | Transfer when        | Payload
// ----------+----------------------+-------------------------------------------
// input     | push && !full        | action, status_in, 3 readings, 6 setpoints
// result    | pop && !empty        | event_kind, alarm_number, reading,
//           |                      | setpoint, status_out, last
// config    | cfg_we               | cfg_wdata -> hysteresis (reset 2)
//
// An item yields one result per detect/clear event (up to six), or a single
// no-event result; the back end emits one result per cycle while the result
// register is free, so items with one result stream at one per cycle unless
// pop stalls. Each item is queued, then held in the current-item register.
// rst_n clears the queue and result register and loads hysteresis with 2.
// A stalled pop backs up through the result register and queue to full.

module sensor_alarm_latch_with_ack #(
    parameter int QUEUE_DEPTH = 2     // front/back queue entries, 2 or more
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    // input queue side
    input  logic              push,
    output logic              full,
    input  logic [1:0]        action,
    input  logic [15:0]       status_in,
    input  logic signed [15:0] temperature,
    input  logic signed [15:0] humidity,
    input  logic signed [15:0] pressure,
    input  logic signed [15:0] temp_low_point,
    input  logic signed [15:0] temp_high_point,
    input  logic signed [15:0] hum_low_point,
    input  logic signed [15:0] hum_high_point,
    input  logic signed [15:0] pres_low_point,
    input  logic signed [15:0] pres_high_point,
    // result queue side
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        event_kind,
    output logic [2:0]        alarm_number,
    output logic signed [15:0] reading,
    output logic signed [15:0] setpoint,
    output logic [15:0]       status_out,
    output logic              last
);
    import sal_pkg::*;

    sal_entry_t  fr_entry;
    sal_entry_t  q_head;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        res_valid;
    sal_result_t res;

    // front: hysteresis register and per-alarm classification, all parallel
    sal_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .action          (action),
        .status_in       (status_in),
        .temperature     (temperature),
        .humidity        (humidity),
        .pressure        (pressure),
        .temp_low_point  (temp_low_point),
        .temp_high_point (temp_high_point),
        .hum_low_point   (hum_low_point),
        .hum_high_point  (hum_high_point),
        .pres_low_point  (pres_low_point),
        .pres_high_point (pres_high_point),
        .entry           (fr_entry)
    );

    // decouples input acceptance from the multi-result walk
    sal_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (fr_entry),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_head),
        .not_empty (q_valid)
    );

    // back: one result per cycle into the result register while it is free
    sal_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .out_valid (res_valid),
        .out_pop   (pop),
        .out_data  (res)
    );

    assign full = q_full;
    assign empty = ~res_valid;
    assign event_kind = res.event_kind;
    assign alarm_number = res.alarm_number;
    assign reading = res.reading;
    assign setpoint = res.setpoint;
    assign status_out = res.status_out;
    assign last = res.last;

endmodule

[rtl/sal_checker.sv]
// Port-level assertions for the sensor alarm latch, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sal_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic [1:0]        event_kind,
    input logic [2:0]        alarm_number,
    input logic signed [15:0] reading,
    input logic signed [15:0] setpoint,
    input logic [15:0]       status_out,
    input logic              last
);
    import sal_pkg::*;

    // nothing can reach the result register in the first cycle out of reset
    `ASSERT_STD(a_empty_after_reset, $rose(rst_n) |-> empty, "result right after reset")

    // a no-event result is always the final one of its item
    `ASSERT_STD(a_none_is_last, (!empty && event_kind == EV_NONE) |-> last, "no-event not last")

    // a no-event result carries zero number, reading and setpoint
    `ASSERT_STD(a_none_zero, (!empty && event_kind == EV_NONE) |-> (alarm_number == 3'd0 && reading == 16'sd0 && setpoint == 16'sd0), "no-event fields not zero")

    // only defined event kinds and alarm numbers
    `ASSERT_STD(a_codes_valid, !empty |-> (event_kind != 2'd3 && alarm_number <= 3'd5), "bad event code")

    // stalled result holds
    `ASSERT_STD(a_hold_on_stall, (!empty && !pop) |=> (!empty && $stable(status_out) && $stable(last)), "result changed under stall")

endmodule

bind sensor_alarm_latch_with_ack sal_checker u_sal_checker (.*);

[bench/tb_sensor_alarm_latch_with_ack.sv]
// Self-checking testbench for the latched hi/lo sensor alarm block with acknowledge.
`timescale 1ns / 1ps

module tb_sensor_alarm_latch_with_ack;
    import sal_pkg::*;

    // Action code 3 has no name in the package; the block passes status through.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles with no transfer on either side before the run is declared hung.
    // The worst legitimate quiet stretch is a 78% stall/idle streak plus a
    // short idle pause between phases, far below this.
    localparam int WATCHDOG_LIMIT = 5000;

    // One input item as the tb keeps it; readings and setpoints are raw
    // 16-bit patterns, sign-extended where the alarm compares are done.
    typedef struct packed {
        logic [1:0]       act;
        logic [15:0]      st;
        logic [2:0][15:0] rd;   // temperature, humidity, pressure
        logic [5:0][15:0] sp;   // setpoints of alarms 0..5
    } alarm_item_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [7:0]        cfg_wdata;
    logic              push;
    logic              full;
    logic [1:0]        action;
    logic [15:0]       status_in;
    logic signed [15:0] temperature;
    logic signed [15:0] humidity;
    logic signed [15:0] pressure;
    logic signed [15:0] temp_low_point;
    logic signed [15:0] temp_high_point;
    logic signed [15:0] hum_low_point;
    logic signed [15:0] hum_high_point;
    logic signed [15:0] pres_low_point;
    logic signed [15:0] pres_high_point;
    logic              empty;
    logic              pop = 1'b0;
    logic [1:0]        event_kind;
    logic [2:0]        alarm_number;
    logic signed [15:0] reading;
    logic signed [15:0] setpoint;
    logic [15:0]       status_out;
    logic              last;

    // tb copy of the hysteresis register, updated on every config write
    logic [7:0]        hyst_shadow;

    // Expected event records, oldest at the front
    sal_result_t       pending_events[$];

    int                sender_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatches = 0;
    int                items_sent = 0;
    int                events_checked = 0;
    int                detects_seen = 0;
    int                clears_seen = 0;
    int                quiet_cycles = 0;

    sensor_alarm_latch_with_ack DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .push            (push),
        .full            (full),
        .action          (action),
        .status_in       (status_in),
        .temperature     (temperature),
        .humidity        (humidity),
        .pressure        (pressure),
        .temp_low_point  (temp_low_point),
        .temp_high_point (temp_high_point),
        .hum_low_point   (hum_low_point),
        .hum_high_point  (hum_high_point),
        .pres_low_point  (pres_low_point),
        .pres_high_point (pres_high_point),
        .empty           (empty),
        .pop             (pop),
        .event_kind      (event_kind),
        .alarm_number    (alarm_number),
        .reading         (reading),
        .setpoint        (setpoint),
        .status_out      (status_out),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Alarm predictor
    // ------------------------------------------------------------------

    function automatic sal_result_t event_record(input logic [1:0] kind, input int num,
                                                 input logic [15:0] rd, input logic [15:0] sp,
                                                 input logic [15:0] st);
        sal_result_t res;
        res.event_kind   = kind;
        res.alarm_number = 3'(num);
        res.reading      = rd;
        res.setpoint     = sp;
        res.status_out   = st;
        res.last         = 1'b0;
        return res;
    endfunction

    // Walks the item through the alarm state machine and queues one record
    // per detect/clear event, or a single no-event record.
    function automatic void predict_alarm_events(input alarm_item_t it);
        logic [15:0] st;
        logic [15:0] det;
        logic [15:0] ack;
        logic [15:0] en;
        logic [15:0] pair;
        int          r;
        int          lim;
        int          hyst;
        int          a;
        int          n_events;
        bit          halted;
        bit          gone;
        sal_result_t evs[$];

        st     = it.st;
        hyst   = hyst_shadow;
        halted = 1'b0;
        if (it.act == ACT_CHECK)
        begin
            for (a = 0; a < NUM_ALARMS; a++)
            begin
                det  = 16'd1 << (2 * a);
                ack  = det << 1;
                en   = 16'd1 << (GROUP_EN_LSB + a / 2);
                r    = $signed(it.rd[a / 2]);
                lim  = $signed(it.sp[a]);
                pair = st & (det | ack);
                // walk stops at the first disabled group
                if ((st & en) == 16'd0)
                    halted = 1'b1;
                if (!halted && pair == (det | ack))
                begin
                    // widened compare: setpoint +/- band never wraps
                    gone = a[0] ? (r < lim - hyst) : (r > lim + hyst);
                    if (gone)
                    begin
                        st &= ~(det | ack);
                        evs.push_back(event_record(EV_CLEAR, a, it.rd[a / 2], it.sp[a], st));
                    end
                end
                else if (!halted && pair == 16'd0)
                begin
                    if (a[0] ? (r >= lim) : (r <= lim))
                    begin
                        st |= st[AUTO_ACK_BIT] ? (det | ack) : det;
                        evs.push_back(event_record(EV_DETECT, a, it.rd[a / 2], it.sp[a], st));
                    end
                end
                // det-only and ack-only pairs hold
            end
        end
        else if (it.act == ACT_ACK)
        begin
            for (a = 0; a < NUM_ALARMS; a++)
            begin
                det = 16'd1 << (2 * a);
                ack = det << 1;
                if ((st & (det | ack)) == det)
                    st |= ack;
            end
        end
        else if (it.act == ACT_OFFSCAN)
        begin
            st &= CONTROL_MASK;
        end

        if (evs.size() == 0)
            evs.push_back(event_record(EV_NONE, 0, 16'd0, 16'd0, st));
        n_events = evs.size();
        evs[n_events - 1].last = 1'b1;
        foreach (evs[i])
            pending_events.push_back(evs[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                          input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_checker
        sal_result_t exp_ev;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual kind %h alarm %h status %h",
                         $time, event_kind, alarm_number, status_out);
                mismatches++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                compare_field("event_kind", 16'(exp_ev.event_kind), 16'(event_kind));
                compare_field("alarm_number", 16'(exp_ev.alarm_number), 16'(alarm_number));
                compare_field("reading", exp_ev.reading, reading);
                compare_field("setpoint", exp_ev.setpoint, setpoint);
                compare_field("status_out", exp_ev.status_out, status_out);
                compare_field("last", 16'(exp_ev.last), 16'(last));
            end
            events_checked++;
            if (event_kind == EV_DETECT)
                detects_seen++;
            if (event_kind == EV_CLEAR)
                clears_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: watchdog, no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_events.size());
                $display("sensor_alarm_latch_with_ack regression: fail");
                $finish;
            end
        end
    end

    // Receiver: pop changes on the falling edge, stall rate set per phase.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one item; push stays high after the transfer so back-to-back
    // items stream. A sender gap in the next send, or the drain, lowers it.
    task automatic send_alarm_item(input alarm_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push            <= 1'b1;
        action          <= it.act;
        status_in       <= it.st;
        temperature     <= it.rd[0];
        humidity        <= it.rd[1];
        pressure        <= it.rd[2];
        temp_low_point  <= it.sp[0];
        temp_high_point <= it.sp[1];
        hum_low_point   <= it.sp[2];
        hum_high_point  <= it.sp[3];
        pres_low_point  <= it.sp[4];
        pres_high_point <= it.sp[5];
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_alarm_events(it);
        items_sent++;
    endtask

    // Stops pushing and waits for every expected result, then waits on
    // so the back end is surely idle.
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_hysteresis(input logic [7:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        hyst_shadow = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // All three readings share one value, all lows one, all highs one.
    function automatic alarm_item_t uniform_item(input logic [1:0] act, input logic [15:0] st,
                                                 input logic [15:0] rd,
                                                 input logic [15:0] low_sp,
                                                 input logic [15:0] high_sp);
        alarm_item_t it;
        it.act = act;
        it.st  = st;
        for (int g = 0; g < NUM_READINGS; g++)
        begin
            it.rd[g]         = rd;
            it.sp[2 * g]     = low_sp;
            it.sp[2 * g + 1] = high_sp;
        end
        return it;
    endfunction

    // Mostly checks with readings placed around a setpoint of their group,
    // so detect, hold and clear all happen; the rest is other actions and
    // fully random readings.
    function automatic alarm_item_t random_alarm_item();
        alarm_item_t it;
        int          pick;
        int          band;
        int          v;
        int          a;
        int          g;
        pick = $urandom_range(99);
        if (pick < 70)
            it.act = ACT_CHECK;
        else if (pick < 82)
            it.act = ACT_ACK;
        else if (pick < 92)
            it.act = ACT_OFFSCAN;
        else
            it.act = ACT_UNUSED;
        it.st = 16'($urandom);
        // keep most items walking all six alarms
        if ($urandom_range(99) < 80)
            it.st[14:12] = 3'b111;
        for (a = 0; a < NUM_ALARMS; a++)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                it.sp[a] = 16'h8000;
            else if (pick < 12)
                it.sp[a] = 16'h7FFF;
            else if (pick < 60)
                it.sp[a] = 16'($urandom_range(2000)) - 16'd1000;
            else
                it.sp[a] = 16'($urandom);
        end
        band = int'(hyst_shadow) + 3;
        for (g = 0; g < NUM_READINGS; g++)
        begin
            if ($urandom_range(99) < 75)
            begin
                v = $signed(it.sp[2 * g + int'($urandom_range(1))]);
                v = v + int'($urandom_range(2 * band)) - band;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                it.rd[g] = 16'(v);
            end
            else
            begin
                it.rd[g] = 16'($urandom);
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Detect, auto-ack, clear, band edges and the two holding pairs,
    // at the reset hysteresis of 2.
    task automatic test_check_walk();
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7000, 16'd0, -16'sd100, 16'sd100));
        // reading equal to both setpoints: every alarm detects
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7000, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_CHECK, 16'hF000, 16'd0, 16'd0, 16'd0));
        // acknowledged alarms well outside the band: all six clear
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7FFF, 16'd0, -16'sd100, 16'sd100));
        // reading right on the band edge holds
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7FFF, 16'd2, 16'd0, 16'd4));
        // lows one past the edge clear, highs on the edge hold
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7FFF, 16'd3, 16'd0, 16'd5));
        // detected but unacknowledged, and acknowledge without detect: wait
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7555, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7AAA, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_CHECK, 16'hF0E4, 16'd0, 16'd0, 16'd0));
    endtask

    // The walk stops at the first disabled group even if later ones are on.
    task automatic test_enable_chain();
        send_alarm_item(uniform_item(ACT_CHECK, 16'h6000, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_CHECK, 16'h5000, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_CHECK, 16'h3000, 16'd0, 16'd0, 16'd0));
    endtask

    // Register extremes against full-scale readings: setpoint plus or minus
    // the band must not wrap at 16 bits.
    task automatic test_hysteresis_extremes();
        write_hysteresis(8'd255);
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7000, 16'h8000, 16'h8000, 16'h7FFF));
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7000, 16'h7FFF, 16'h8000, 16'h7FFF));
        write_hysteresis(8'd0);
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7FFF, 16'd1, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_CHECK, 16'h7FFF, 16'd0, 16'd0, 16'd0));
        write_hysteresis(HYST_RESET);
    endtask

    // Acknowledge ignores the enables, off-scan keeps control bits,
    // the unused code passes status through.
    task automatic test_other_actions();
        send_alarm_item(uniform_item(ACT_ACK, 16'h0555, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_ACK, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_ACK, 16'h88E4, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_OFFSCAN, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_OFFSCAN, 16'h0FFF, 16'd0, 16'd0, 16'd0));
        send_alarm_item(uniform_item(ACT_UNUSED, 16'hA5C3, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [7:0] hyst, input int n_items);
        write_hysteresis(hyst);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (n_items)
            send_alarm_item(random_alarm_item());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 8'd0;
        push            = 1'b0;
        action          = ACT_CHECK;
        status_in       = 16'd0;
        temperature     = 16'sd0;
        humidity        = 16'sd0;
        pressure        = 16'sd0;
        temp_low_point  = 16'sd0;
        temp_high_point = 16'sd0;
        hum_low_point   = 16'sd0;
        hum_high_point  = 16'sd0;
        pres_low_point  = 16'sd0;
        pres_high_point = 16'sd0;
        hyst_shadow     = HYST_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_check_walk();
        test_enable_chain();
        test_hysteresis_extremes();
        test_other_actions();

        // four handshake profiles, each under its own hysteresis
        run_random_traffic(0, 0, 8'd0, 52);
        run_random_traffic(78, 0, 8'd255, 52);
        run_random_traffic(0, 78, 8'($urandom_range(1, 254)), 52);
        run_random_traffic(31, 31, 8'd7, 52);

        repeat (20) @(posedge clk);
        $display("Ran %0d items, checked %0d results (%0d detects, %0d clears).",
                 items_sent, events_checked, detects_seen, clears_seen);
        $display("Hysteresis 0, 2, 255 and mid values; idle, sender gaps, receiver stalls, both.");
        if (mismatches == 0 && pending_events.size() == 0)
            $display("sensor_alarm_latch_with_ack regression: pass");
        else
            $display("sensor_alarm_latch_with_ack regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sal_pkg.sv
rtl/sal_front.sv
rtl/sal_queue.sv
rtl/sal_back.sv
rtl/sensor_alarm_latch_with_ack.sv
rtl/sal_checker.sv
bench/tb_sensor_alarm_latch_with_ack.sv
